// ----- hdl/shbf_pkg.sv -----
// shared widths, command codes and hash constants of the single-hash bloom filter
package shbf_pkg;

  localparam int unsigned HASH_W    = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FB_W      = 13;
  localparam int unsigned IDX_W     = FB_W + 3;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 72;

  localparam int unsigned MAX_FILTER_BYTES_DEF = 4096;
  localparam logic [FB_W-1:0] FB_RESET = 13'd4096;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;

  localparam logic [CMD_W-1:0] CMD_INS_STR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SRCH_STR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INS_HASH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SRCH_HASH = 2'd3;

endpackage

// ----- hdl/shbf_rem.sv -----
// iterative remainder unit: one quotient bit per cycle, restoring
module shbf_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [shbf_pkg::HASH_W-1:0] dividend,
  input  logic [shbf_pkg::IDX_W-1:0]  divisor,
  output logic                       done,
  output logic [shbf_pkg::IDX_W-1:0]  remainder
);
  import shbf_pkg::*;

  localparam int unsigned CNT_W = $clog2(HASH_W);

  logic [HASH_W-1:0] dvd_r;
  logic [IDX_W-1:0]  dsr_r;
  logic [IDX_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [IDX_W:0]    trial;
  logic [IDX_W+1:0]  diff;

  assign trial = {rem_r, dvd_r[HASH_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r <= dividend;
        dsr_r <= divisor;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        dvd_r <= {dvd_r[HASH_W-2:0], 1'b0};
        // borrow means the trial stays below the divisor
        rem_r <= diff[IDX_W+1] ? trial[IDX_W-1:0] : diff[IDX_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(HASH_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ----- hdl/single_hash_bloom_filter.sv -----
// top level of the single-hash bloom filter with fnv-1 string hashing
// A lookup item (a hash command, or the string byte marked last) is accepted, then passes
// through the shared bit-serial remainder unit that reduces the hash modulo
// filter_bytes*8, then the registered bit-store read, then a step that sets the bit and
// loads the output register, which waits while the receiver holds the previous result.
// String bytes that are not marked last are folded into the running FNV-1 hash in the
// accept cycle and leave in_tready high. After reset a clearing pass writes zero to the
// bit store, one byte per cycle, over all MAX_FILTER_BYTES bytes; no item is accepted during
// it, while configuration writes are taken. filter_bytes of 0 acts as 1 and values above
// MAX_FILTER_BYTES act as MAX_FILTER_BYTES; changing it does not clear the store.
module single_hash_bloom_filter #(
  parameter int unsigned MAX_FILTER_BYTES = shbf_pkg::MAX_FILTER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config
  input  logic                            cfg_we,
  input  logic [shbf_pkg::FB_W-1:0]       cfg_wdata,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [shbf_pkg::IN_DATA_W-1:0]  in_tdata,   // data_byte[7:0], hash_value[39:8]
  input  logic                            in_tlast,   // last_byte
  input  logic [shbf_pkg::CMD_W-1:0]      in_tuser,   // command[1:0]
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [shbf_pkg::OUT_DATA_W-1:0] out_tdata   // found[0], hash_used[32:1],
                                                      // item_count[64:33], zeros[71:65]
);
  import shbf_pkg::*;

  localparam int unsigned AW = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
  localparam int unsigned IW = (AW > FB_W) ? AW : FB_W;
  localparam int unsigned FB_MAX = (1 << FB_W) - 1;
  localparam int unsigned CLAMP = (MAX_FILTER_BYTES > FB_MAX) ? FB_MAX : MAX_FILTER_BYTES;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOOK
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       clr_addr_r;
  logic [FB_W-1:0]     fb_r;
  logic [HASH_W-1:0]   rh_r;
  logic [HASH_W-1:0]   hash_r;
  logic                ins_r;
  logic [HASH_W-1:0]   count_r;
  logic [AW-1:0]       addr_r;
  logic [2:0]          bit_r;
  logic [BYTE_W-1:0]   rd_r;
  logic                out_valid_r;
  logic                out_found_r;
  logic [HASH_W-1:0]   out_hash_r;
  logic [HASH_W-1:0]   out_count_r;

  logic [BYTE_W-1:0]   mem [MAX_FILTER_BYTES];

  logic [CMD_W-1:0]    cmd;
  logic [BYTE_W-1:0]   data_byte;
  logic [HASH_W-1:0]   hash_value;
  logic                in_fire;
  logic                is_hash_cmd;
  logic                is_insert;
  logic                start_lookup;
  logic [HASH_W-1:0]   fnv_nxt;
  logic [HASH_W-1:0]   lookup_hash;
  logic [FB_W-1:0]     eff_bytes;
  logic [IDX_W-1:0]    divisor;
  logic                rem_done;
  logic [IDX_W-1:0]    rem_idx;
  logic [IW-1:0]       byte_wide;
  logic                out_free;
  logic                look_go;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [BYTE_W-1:0]   mem_wd;
  logic [BYTE_W-1:0]   bit_mask;

  assign cmd        = in_tuser;
  assign data_byte  = in_tdata[BYTE_W-1:0];
  assign hash_value = in_tdata[BYTE_W +: HASH_W];

  assign in_tready    = (state_r == ST_IDLE);
  assign in_fire      = in_tvalid && in_tready;
  assign is_hash_cmd  = (cmd == CMD_INS_HASH) || (cmd == CMD_SRCH_HASH);
  assign is_insert    = (cmd == CMD_INS_HASH) || (cmd == CMD_INS_STR);
  assign start_lookup = in_fire && (is_hash_cmd || in_tlast);

  assign fnv_nxt     = (rh_r * FNV_PRIME) ^ {{(HASH_W-BYTE_W){1'b0}}, data_byte};
  assign lookup_hash = is_hash_cmd ? hash_value : fnv_nxt;

  always_comb begin
    if (fb_r == '0) begin
      eff_bytes = FB_W'(1);
    end else if (32'(fb_r) > MAX_FILTER_BYTES) begin
      eff_bytes = FB_W'(CLAMP);
    end else begin
      eff_bytes = fb_r;
    end
  end

  assign divisor = {eff_bytes, 3'b000};

  shbf_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_lookup),
    .dividend  (lookup_hash),
    .divisor   (divisor),
    .done      (rem_done),
    .remainder (rem_idx)
  );

  // byte index is below the effective size, so the narrowing is lossless
  assign byte_wide = IW'(rem_idx[IDX_W-1:3]);

  assign out_free = !out_valid_r || out_tready;
  assign look_go  = (state_r == ST_LOOK) && out_free;
  assign bit_mask = BYTE_W'(1) << bit_r;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else begin
      mem_we = look_go && ins_r;
      mem_wa = addr_r;
      mem_wd = rd_r | bit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      fb_r        <= FB_RESET;
      rh_r        <= FNV_BASIS;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fb_r <= cfg_wdata;
      end
      if (look_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(MAX_FILTER_BYTES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            if (!is_hash_cmd) begin
              rh_r <= in_tlast ? FNV_BASIS : fnv_nxt;
            end
            if (start_lookup) begin
              hash_r  <= lookup_hash;
              ins_r   <= is_insert;
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (rem_done) begin
            addr_r  <= byte_wide[AW-1:0];
            bit_r   <= rem_idx[2:0];
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_LOOK;
        end
        ST_LOOK: begin
          if (out_free) begin
            out_hash_r  <= hash_r;
            if (ins_r) begin
              out_found_r <= 1'b0;
              out_count_r <= count_r + 1'b1;
              count_r     <= count_r + 1'b1;
            end else begin
              out_found_r <= |(rd_r & bit_mask);
              out_count_r <= count_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2*HASH_W - 1){1'b0}}, out_count_r, out_hash_r,
                       out_found_r};

endmodule

// ----- bench/tb_single_hash_bloom_filter.sv -----
// self-checking testbench for the single-hash bloom filter with fnv-1 string hashing
module tb_single_hash_bloom_filter;
  import shbf_pkg::*;

  localparam int unsigned MAX_BYTES     = MAX_FILTER_BYTES_DEF;
  localparam int unsigned LOOKUP_CYCLES = 35;
  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned PHASE_ITEMS   = 95;
  localparam int          NUM_PHASES    = 9;
  localparam int          NUM_DIR       = 25;
  localparam int          STR_POOL      = 8;
  localparam int          STR_MAX       = 6;

  typedef struct packed {
    bit              found;
    bit [HASH_W-1:0] hash_used;
    bit [HASH_W-1:0] item_count;
  } lookup_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [HASH_W-1:0] hash;
    bit                typed;
    lookup_t           res;
  } dir_row_t;

  // typed rows hold results that follow straight from an empty store of 32768 bits
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{CMD_SRCH_HASH, 8'h00, 1'b0, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 32'd0}},
    '{CMD_INS_HASH,  8'hff, 1'b1, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 32'd1}},
    '{CMD_SRCH_HASH, 8'h00, 1'b0, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 32'd1}},
    '{CMD_SRCH_HASH, 8'h00, 1'b0, 32'hffff_ffff, 1'b1, '{1'b0, 32'hffff_ffff, 32'd1}},
    '{CMD_INS_HASH,  8'h00, 1'b0, 32'hffff_ffff, 1'b1, '{1'b0, 32'hffff_ffff, 32'd2}},
    '{CMD_SRCH_HASH, 8'h00, 1'b1, 32'hffff_ffff, 1'b1, '{1'b1, 32'hffff_ffff, 32'd2}},
    '{CMD_INS_STR,   8'h00, 1'b1, 32'h0000_0000, 1'b0, '0},
    '{CMD_SRCH_STR,  8'h00, 1'b1, 32'h0000_0000, 1'b0, '0},
    '{CMD_INS_STR,   8'hff, 1'b1, 32'hffff_ffff, 1'b0, '0},
    '{CMD_SRCH_STR,  8'hff, 1'b1, 32'hffff_ffff, 1'b0, '0},
    // hash lookup in the middle of a string
    '{CMD_INS_STR,   8'h61, 1'b0, 32'h0000_0000, 1'b0, '0},
    '{CMD_SRCH_HASH, 8'h00, 1'b0, 32'h5555_aaaa, 1'b0, '0},
    '{CMD_INS_STR,   8'h62, 1'b1, 32'h0000_0000, 1'b0, '0},
    // mixed commands, the last byte makes it a search
    '{CMD_INS_STR,   8'h61, 1'b0, 32'h0000_0000, 1'b0, '0},
    '{CMD_SRCH_STR,  8'h62, 1'b1, 32'h0000_0000, 1'b0, '0},
    '{CMD_INS_HASH,  8'h00, 1'b1, 32'haaaa_5555, 1'b0, '0},
    '{CMD_SRCH_HASH, 8'h00, 1'b1, 32'haaaa_5555, 1'b0, '0},
    '{CMD_INS_HASH,  8'h00, 1'b0, 32'h0000_8000, 1'b0, '0},
    '{CMD_SRCH_STR,  8'h80, 1'b1, 32'h0000_0000, 1'b0, '0},
    '{CMD_INS_STR,   8'h12, 1'b0, 32'h0000_0000, 1'b0, '0},
    '{CMD_INS_STR,   8'h34, 1'b0, 32'h0000_0000, 1'b0, '0},
    '{CMD_INS_STR,   8'h56, 1'b1, 32'h0000_0000, 1'b0, '0},
    '{CMD_SRCH_STR,  8'h12, 1'b0, 32'h0000_0000, 1'b0, '0},
    '{CMD_SRCH_STR,  8'h34, 1'b0, 32'h0000_0000, 1'b0, '0},
    '{CMD_SRCH_STR,  8'h56, 1'b1, 32'h0000_0000, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [FB_W-1:0]       cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // data_byte[7:0], hash_value[39:8]
  logic                  in_tlast;   // last_byte
  logic [CMD_W-1:0]      in_tuser;   // command[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // found[0], hash_used[32:1], item_count[64:33]

  // filter mirror
  bit              bloom_bits [MAX_BYTES*8];
  bit [HASH_W-1:0] fnv_acc;
  bit [HASH_W-1:0] insert_tally;
  bit [FB_W-1:0]   fb_setting;

  lookup_t           awaited_lookups [$];
  bit [HASH_W-1:0]   hash_pool [$];
  logic [BYTE_W-1:0] pool_bytes [STR_POOL][STR_MAX];
  int                pool_len [STR_POOL];
  int                fail_count = 0;
  int                items_sent;
  int unsigned       quiet_cycles = 0;
  bit                no_gaps;

  single_hash_bloom_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic lookup_t probe_filter(bit ins, bit [HASH_W-1:0] h);
    int unsigned span;
    int unsigned idx;
    lookup_t r;
    span = (fb_setting == 0) ? 1 : ((fb_setting > MAX_BYTES) ? MAX_BYTES : fb_setting);
    idx = h % (span * 8);
    r = '0;
    if (ins) begin
      bloom_bits[idx] = 1'b1;
      insert_tally = insert_tally + 1;
    end else begin
      r.found = bloom_bits[idx];
    end
    r.hash_used = h;
    r.item_count = insert_tally;
    return r;
  endfunction

  // returns 1 when the item completes a lookup
  function automatic bit bloom_predict(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                       logic last, logic [HASH_W-1:0] hv, output lookup_t r);
    bit [HASH_W-1:0] h;
    r = '0;
    if (cmd == CMD_INS_HASH || cmd == CMD_SRCH_HASH) begin
      r = probe_filter(cmd == CMD_INS_HASH, hv);
      return 1'b1;
    end
    fnv_acc = (fnv_acc * FNV_PRIME) ^ {24'd0, data};
    if (!last) return 1'b0;
    h = fnv_acc;
    fnv_acc = FNV_BASIS;
    r = probe_filter(cmd == CMD_INS_STR, h);
    return 1'b1;
  endfunction

  task automatic drive_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data, logic last,
                            logic [HASH_W-1:0] hv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {hv, data};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic issue(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data, logic last,
                       logic [HASH_W-1:0] hv);
    lookup_t r;
    drive_item(cmd, data, last, hv);
    items_sent++;
    if (bloom_predict(cmd, data, last, hv, r)) begin
      awaited_lookups.push_back(r);
      hash_pool.push_back(r.hash_used);
      if (hash_pool.size() > 32) void'(hash_pool.pop_front());
    end
  endtask

  task automatic send_hash();
    logic [HASH_W-1:0] hv;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && hash_pool.size() > 0) hv = hash_pool[$urandom_range(0, hash_pool.size() - 1)];
    else if (r < 55) hv = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
    else if (r < 65) hv = $urandom_range(0, 4095);
    else hv = $urandom;
    issue($urandom_range(0, 1) ? CMD_INS_HASH : CMD_SRCH_HASH, 8'($urandom), 1'($urandom), hv);
  endtask

  task automatic send_string();
    int len;
    int sel;
    bit mixed;
    bit ins;
    bit fresh;
    logic [BYTE_W-1:0] b;
    logic [CMD_W-1:0] cmd;
    ins = $urandom_range(0, 1);
    mixed = ($urandom_range(0, 99) < 15);
    fresh = $urandom_range(0, 1);
    sel = $urandom_range(0, STR_POOL - 1);
    len = fresh ? $urandom_range(1, STR_MAX) : pool_len[sel];
    for (int k = 0; k < len; k++) begin
      b = fresh ? 8'($urandom) : pool_bytes[sel][k];
      if (mixed) cmd = $urandom_range(0, 1) ? CMD_SRCH_STR : CMD_INS_STR;
      else cmd = ins ? CMD_INS_STR : CMD_SRCH_STR;
      if (k < len - 1 && $urandom_range(0, 99) < 8) send_hash();
      issue(cmd, b, k == len - 1, $urandom);
    end
  endtask

  // lets the last lookup drain before the size register changes
  task automatic settle();
    in_tvalid <= 1'b0;
    while (awaited_lookups.size() != 0) @(negedge clk);
    repeat (LOOKUP_CYCLES + 5) @(negedge clk);
  endtask

  task automatic write_filter_bytes(bit [FB_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    fb_setting = v;
  endtask

  // receiver side
  initial begin
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (!no_gaps && $urandom_range(0, 99) < 20) begin
        out_tready <= 1'b0;
        stall = pick_gap();
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.found      = out_tdata[0];
      got.hash_used  = out_tdata[32:1];
      got.item_count = out_tdata[64:33];
      if (awaited_lookups.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected item: found %0d hash %h count %0d",
                   got.found, got.hash_used, got.item_count);
      end else begin
        want = awaited_lookups.pop_front();
        if (got.found != want.found || got.hash_used != want.hash_used ||
            got.item_count != want.item_count) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected found %0d hash %h count %0d, got %0d %h %0d",
                     want.found, want.hash_used, want.item_count,
                     got.found, got.hash_used, got.item_count);
        end
      end
    end
  end

  // watchdog: the clearing pass after reset is the longest legal quiet stretch
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    lookup_t r;
    int pick;
    int phase_start;
    bit [FB_W-1:0] fb_next;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tlast     <= 1'b0;
    in_tuser     <= CMD_INS_STR;
    items_sent   = 0;
    no_gaps      = 1'b0;
    fnv_acc      = FNV_BASIS;
    insert_tally = '0;
    fb_setting   = FB_RESET;
    for (int i = 0; i < STR_POOL; i++) begin
      pool_len[i] = $urandom_range(1, STR_MAX);
      for (int k = 0; k < STR_MAX; k++) pool_bytes[i][k] = 8'($urandom);
    end
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      drive_item(DIR_ROWS[i].cmd, DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].hash);
      if (bloom_predict(DIR_ROWS[i].cmd, DIR_ROWS[i].data, DIR_ROWS[i].last,
                        DIR_ROWS[i].hash, r))
        awaited_lookups.push_back(DIR_ROWS[i].typed ? DIR_ROWS[i].res : r);
    end

    // smallest, all-ones, zero, largest and just-above-range sizes among the phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: fb_next = 13'd1;
        1: fb_next = 13'd8191;
        2: fb_next = 13'd0;
        3: fb_next = 13'd4096;
        4: fb_next = 13'd3;
        5: fb_next = 13'd4097;
        7: fb_next = 13'd64;
        default: fb_next = FB_W'($urandom_range(1, MAX_BYTES));
      endcase
      write_filter_bytes(fb_next);
      no_gaps = (p % 3 == 1);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) send_hash();
        else if (pick < 90) send_string();
        else issue($urandom_range(0, 1) ? CMD_SRCH_STR : CMD_INS_STR, 8'($urandom),
                   1'($urandom), $urandom);
      end
    end

    no_gaps = 1'b0;
    in_tvalid <= 1'b0;
    while (awaited_lookups.size() != 0) @(posedge clk);
    repeat (LOOKUP_CYCLES + 5) @(posedge clk);
    if (fail_count == 0 && awaited_lookups.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
